// File: hdl/mal_pkg.sv
// Shared types and mode codes for the multiply-accumulate-long pipeline.
package mal_pkg;

    localparam logic [2:0] MODE_MUL   = 3'd0;
    localparam logic [2:0] MODE_MLA   = 3'd1;
    localparam logic [2:0] MODE_UMULL = 3'd2;
    localparam logic [2:0] MODE_UMLAL = 3'd3;
    localparam logic [2:0] MODE_SMULL = 3'd4;
    localparam logic [2:0] MODE_SMLAL = 3'd5;

    localparam int WORD_W = 32;
    localparam int LONG_W = 64;

    // per-item control that rides along the pipe
    typedef struct packed {
        logic op_valid;   // defined mode
        logic long_op;    // 64-bit result forms
        logic flag_update;
    } ctrl_t;

    // product stage to adder stage
    typedef struct packed {
        ctrl_t             ctrl;
        logic [LONG_W-1:0] prod;     // unsigned 32x32 product
        logic [LONG_W-1:0] acc_adj;  // accumulator minus signed correction
    } prod_t;

    // adder stage to output stage
    typedef struct packed {
        ctrl_t             ctrl;
        logic [LONG_W-1:0] sum;
    } sum_t;

endpackage

// File: hdl/multiply_accumulate_long.sv
// Top level of the pipelined 32x32 multiply / multiply-accumulate-long unit.
//
//  channel  dir  tdata                                   tuser
//  s_       in   128b: multiplicand, multiplier,         4b: mode, flag_update
//                      accum_low, accum_high
//  m_       out  72b:  result_low, result_high,          2b: high_valid, flags_write
//                      flag_negative, flag_zero, 6b zero
//
// Four register stages: operand decode, 32x32 unsigned multiply (signed
// correction folded into the accumulator), 64-bit accumulate add, flags/output.
// One item per cycle is sustained while the output is not stalled.
// aresetn is synchronous, active low, and clears all stage valid bits.
// The whole pipe advances when the output register is empty or being taken, so
// a stall freezes every stage in place; s_tready follows the same condition.
module multiply_accumulate_long
    import mal_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // multiplicand, multiplier, accum_low, accum_high
    input  logic [3:0]   s_tuser,   // mode[2:0], flag_update
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // result_low, result_high, flag_negative, flag_zero, pad
    output logic [1:0]   m_tuser    // high_valid, flags_write
);

    logic              adv;
    logic              p_valid, a_valid;
    prod_t             p_data;
    sum_t              a_data;
    logic [WORD_W-1:0] result_low, result_high;
    logic              high_valid, flags_write, flag_negative, flag_zero;

    // global pipe enable: room in the output register
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    mal_mult u_mult (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .mode         (s_tuser[2:0]),
        .flag_update  (s_tuser[3]),
        .multiplicand (s_tdata[31:0]),
        .multiplier   (s_tdata[63:32]),
        .accum_low    (s_tdata[95:64]),
        .accum_high   (s_tdata[127:96]),
        .out_valid    (p_valid),
        .out_data     (p_data)
    );

    mal_add u_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (p_valid),
        .in_data   (p_data),
        .out_valid (a_valid),
        .out_data  (a_data)
    );

    mal_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (a_valid),
        .in_data       (a_data),
        .out_valid     (m_tvalid),
        .result_low    (result_low),
        .result_high   (result_high),
        .high_valid    (high_valid),
        .flags_write   (flags_write),
        .flag_negative (flag_negative),
        .flag_zero     (flag_zero)
    );

    assign m_tdata = {6'b0, flag_zero, flag_negative, result_high, result_low};
    assign m_tuser = {flags_write, high_valid};

`ifndef SYNTHESIS
    // short forms and undefined modes never drive the high word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[63:32] == 32'd0)
        else $error("high word nonzero without high_valid");

    // flags stay clear unless a flag update is requested
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[65:64] == 2'b00)
        else $error("flags set without flags_write");

    // a zero result cannot be negative
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65] |-> !m_tdata[64])
        else $error("zero and negative flags both set");

    // short-form Z agrees with the low word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[65] && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("zero flag with nonzero short result");

    // reset empties the pipe
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

// File: hdl/mal_mult.sv
// Decode/operand register stage and unsigned multiply stage.
module mal_mult
    import mal_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [2:0]        mode,
    input  logic              flag_update,
    input  logic [WORD_W-1:0] multiplicand,
    input  logic [WORD_W-1:0] multiplier,
    input  logic [WORD_W-1:0] accum_low,
    input  logic [WORD_W-1:0] accum_high,
    output logic              out_valid,
    output prod_t             out_data
);

    logic              s1_valid_reg;
    ctrl_t             s1_ctrl_reg;
    logic              s1_signed_reg;
    logic [WORD_W-1:0] s1_a_reg;
    logic [WORD_W-1:0] s1_b_reg;
    logic [LONG_W-1:0] s1_acc_reg;

    ctrl_t             s1_ctrl_next;
    logic              s1_signed_next;
    logic [LONG_W-1:0] s1_acc_next;

    logic              s2_valid_reg;
    prod_t             s2_data_reg;
    prod_t             s2_data_next;
    logic [WORD_W-1:0] corr;

    always_comb begin
        s1_ctrl_next   = '0;
        s1_signed_next = 1'b0;
        s1_acc_next    = '0;
        s1_ctrl_next.flag_update = flag_update;
        case (mode)
            MODE_MUL: begin
                s1_ctrl_next.op_valid = 1'b1;
            end
            MODE_MLA: begin
                s1_ctrl_next.op_valid = 1'b1;
                s1_acc_next = {{WORD_W{1'b0}}, accum_low};
            end
            MODE_UMULL: begin
                s1_ctrl_next.op_valid = 1'b1;
                s1_ctrl_next.long_op  = 1'b1;
            end
            MODE_UMLAL: begin
                s1_ctrl_next.op_valid = 1'b1;
                s1_ctrl_next.long_op  = 1'b1;
                s1_acc_next = {accum_high, accum_low};
            end
            MODE_SMULL: begin
                s1_ctrl_next.op_valid = 1'b1;
                s1_ctrl_next.long_op  = 1'b1;
                s1_signed_next = 1'b1;
            end
            MODE_SMLAL: begin
                s1_ctrl_next.op_valid = 1'b1;
                s1_ctrl_next.long_op  = 1'b1;
                s1_signed_next = 1'b1;
                s1_acc_next = {accum_high, accum_low};
            end
            default: begin
                s1_ctrl_next = '0;
            end
        endcase
    end

    // signed product = unsigned product - 2^32 * (a31 ? b : 0) - 2^32 * (b31 ? a : 0)
    always_comb begin
        corr = '0;
        if (s1_signed_reg) begin
            corr = (s1_a_reg[WORD_W-1] ? s1_b_reg : '0)
                 + (s1_b_reg[WORD_W-1] ? s1_a_reg : '0);
        end
        s2_data_next.ctrl    = s1_ctrl_reg;
        s2_data_next.prod    = {{WORD_W{1'b0}}, s1_a_reg} * {{WORD_W{1'b0}}, s1_b_reg};
        s2_data_next.acc_adj = s1_acc_reg - {corr, {WORD_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
        if (adv) begin
            s1_ctrl_reg   <= s1_ctrl_next;
            s1_signed_reg <= s1_signed_next;
            s1_a_reg      <= multiplicand;
            s1_b_reg      <= multiplier;
            s1_acc_reg    <= s1_acc_next;
            s2_data_reg   <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

// File: hdl/mal_add.sv
// Accumulate stage: adds the adjusted accumulator to the product.
module mal_add
    import mal_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  logic  in_valid,
    input  prod_t in_data,
    output logic  out_valid,
    output sum_t  out_data
);

    logic valid_reg;
    sum_t data_reg;
    sum_t data_next;

    always_comb begin
        data_next.ctrl = in_data.ctrl;
        data_next.sum  = in_data.prod + in_data.acc_adj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/mal_out.sv
// Output stage: result formatting, N/Z flags and output register.
module mal_out
    import mal_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  sum_t              in_data,
    output logic              out_valid,
    output logic [WORD_W-1:0] result_low,
    output logic [WORD_W-1:0] result_high,
    output logic              high_valid,
    output logic              flags_write,
    output logic              flag_negative,
    output logic              flag_zero
);

    logic              valid_reg;
    logic [WORD_W-1:0] lo_reg, hi_reg, lo_next, hi_next;
    logic              hv_reg, fw_reg, fn_reg, fz_reg;
    logic              hv_next, fw_next, fn_next, fz_next;
    logic              zero_lo, zero_hi;

    always_comb begin
        zero_lo = (in_data.sum[WORD_W-1:0] == '0);
        zero_hi = (in_data.sum[LONG_W-1:WORD_W] == '0);
        lo_next = '0;
        hi_next = '0;
        hv_next = 1'b0;
        fw_next = 1'b0;
        fn_next = 1'b0;
        fz_next = 1'b0;
        if (in_data.ctrl.op_valid) begin
            lo_next = in_data.sum[WORD_W-1:0];
            fw_next = in_data.ctrl.flag_update;
            if (in_data.ctrl.long_op) begin
                hi_next = in_data.sum[LONG_W-1:WORD_W];
                hv_next = 1'b1;
                fn_next = in_data.ctrl.flag_update & in_data.sum[LONG_W-1];
                fz_next = in_data.ctrl.flag_update & zero_lo & zero_hi;
            end else begin
                fn_next = in_data.ctrl.flag_update & in_data.sum[WORD_W-1];
                fz_next = in_data.ctrl.flag_update & zero_lo;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            hv_reg <= hv_next;
            fw_reg <= fw_next;
            fn_reg <= fn_next;
            fz_reg <= fz_next;
        end
    end

    assign out_valid     = valid_reg;
    assign result_low    = lo_reg;
    assign result_high   = hi_reg;
    assign high_valid    = hv_reg;
    assign flags_write   = fw_reg;
    assign flag_negative = fn_reg;
    assign flag_zero     = fz_reg;

endmodule

// File: tb/multiply_accumulate_long_tb.sv
// Self-checking testbench for the multiply_accumulate_long stream unit.
`timescale 1ns / 100ps

module multiply_accumulate_long_tb;
    import mal_pkg::*;

    // mode encodings outside the defined set; the unit must emit an all-zero item
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 16;       // well past the pipe latency
    localparam int CYCLE_LIMIT  = 200000;

    // one multiply request as seen on the input channel
    typedef struct {
        logic [2:0]  mode;
        logic        flag_update;
        logic [31:0] mcand;
        logic [31:0] mplier;
        logic [31:0] acc_lo;
        logic [31:0] acc_hi;
    } mac_op_t;

    // one product item as seen on the result channel
    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        hv;
        logic        fw;
        logic        fn;
        logic        fz;
    } mac_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;
    logic [1:0]   m_tuser;

    mac_op_t     op_queue[$];       // requests not yet taken by the unit
    mac_result_t product_queue[$];  // products owed by the unit, oldest first

    int errors      = 0;
    int sent_count  = 0;
    int cycle_count = 0;
    int burst_left  = 1;
    int gap_left    = 0;
    int ready_pct   = 100;
    bit last_taken  = 1'b0;

    multiply_accumulate_long uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Product of one request. Short forms wrap at 32 bits, long forms at 64;
    // signed long forms sign-extend both sources before the 64-bit multiply.
    function automatic mac_result_t predict_mac(mac_op_t op);
        mac_result_t r;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] full;
        r = '{lo: '0, hi: '0, hv: 1'b0, fw: 1'b0, fn: 1'b0, fz: 1'b0};
        x = {32'd0, op.mcand};
        y = {32'd0, op.mplier};
        case (op.mode)
            MODE_MUL, MODE_MLA: begin
                full = x * y;
                if (op.mode == MODE_MLA)
                    full = full + {32'd0, op.acc_lo};
                r.lo = full[31:0];
                r.fw = op.flag_update;
                if (op.flag_update) begin
                    r.fn = r.lo[31];
                    r.fz = (r.lo == 32'd0);
                end
            end
            MODE_UMULL, MODE_UMLAL, MODE_SMULL, MODE_SMLAL: begin
                if (op.mode == MODE_SMULL || op.mode == MODE_SMLAL) begin
                    x = {{32{op.mcand[31]}}, op.mcand};
                    y = {{32{op.mplier[31]}}, op.mplier};
                end
                full = x * y;
                if (op.mode == MODE_UMLAL || op.mode == MODE_SMLAL)
                    full = full + {op.acc_hi, op.acc_lo};
                r.lo = full[31:0];
                r.hi = full[63:32];
                r.hv = 1'b1;
                r.fw = op.flag_update;
                if (op.flag_update) begin
                    r.fn = full[63];
                    r.fz = (full == 64'd0);
                end
            end
            default: ;  // undefined mode: nothing written, nothing flagged
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 15));
            5:       return ~32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [2:0] mode, logic sf, logic [31:0] a, logic [31:0] b,
                            logic [31:0] al, logic [31:0] ah);
        mac_op_t op;
        op = '{mode: mode, flag_update: sf, mcand: a, mplier: b, acc_lo: al, acc_hi: ah};
        op_queue.push_back(op);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
        end
    endtask

    // Request stream: a directed set first, then random requests.
    initial begin
        mac_op_t     op;
        mac_op_t     base;
        mac_result_t base_res;

        // extremes of every mode, flags on
        queue_op(MODE_MUL,   1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(MODE_MUL,   1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        queue_op(MODE_MUL,   1'b1, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0);
        queue_op(MODE_MLA,   1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0);
        queue_op(MODE_MLA,   1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
        queue_op(MODE_UMULL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        // long form with a zero low word but nonzero high word: Z must stay clear
        queue_op(MODE_UMULL, 1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        queue_op(MODE_UMULL, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(MODE_UMLAL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        queue_op(MODE_UMLAL, 1'b1, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        queue_op(MODE_SMULL, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
        queue_op(MODE_SMULL, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_op(MODE_SMULL, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0);
        // -1 * 1 + 1 wraps to zero across the full 64 bits
        queue_op(MODE_SMLAL, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h0);
        queue_op(MODE_SMLAL, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF);
        // flags not requested: N and Z stay low even on negative or zero products
        queue_op(MODE_MUL,   1'b0, 32'h0, 32'h5, 32'h0, 32'h0);
        queue_op(MODE_MLA,   1'b0, 32'h8000_0000, 32'h1, 32'h0, 32'h0);
        queue_op(MODE_UMLAL, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);
        queue_op(MODE_SMULL, 1'b0, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0);
        queue_op(MODE_SMLAL, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        // undefined modes: all result fields zero, flags request ignored
        queue_op(MODE_UNDEF_LO, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        queue_op(MODE_UNDEF_HI, 1'b1, 32'h8000_0000, 32'h0000_0003, 32'h1, 32'h1);
        queue_op(MODE_UNDEF_HI, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 19) == 0)
                op.mode = 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
            else
                op.mode = 3'($urandom_range(MODE_MUL, MODE_SMLAL));
            op.flag_update = 1'($urandom_range(0, 1));
            op.mcand  = pick_word();
            op.mplier = pick_word();
            op.acc_lo = pick_word();
            op.acc_hi = pick_word();
            // now and then cancel the product so the zero flag gets exercised
            if (op.mode inside {MODE_MLA, MODE_UMLAL, MODE_SMLAL} &&
                $urandom_range(0, 7) == 0) begin
                base = op;
                if (op.mode == MODE_MLA)
                    base.mode = MODE_MUL;
                else if (op.mode == MODE_UMLAL)
                    base.mode = MODE_UMULL;
                else
                    base.mode = MODE_SMULL;
                base_res = predict_mac(base);
                {op.acc_hi, op.acc_lo} = -{base_res.hi, base_res.lo};
            end
            op_queue.push_back(op);
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (op_queue.size() != 0 || product_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && product_queue.size() == 0)
            $display("multiply_accumulate_long: match");
        else
            $display("multiply_accumulate_long: mismatch");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps. Valid is held
    // with its data until taken. Some stretches of items run with no gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !last_taken) begin
            // item still waiting for s_tready; keep it on the bus
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (op_queue.size() == 0) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata  <= {op_queue[0].acc_hi, op_queue[0].acc_lo,
                         op_queue[0].mplier, op_queue[0].mcand};
            s_tuser  <= {op_queue[0].flag_update, op_queue[0].mode};
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left = ((sent_count / 150) % 3 == 1) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // Receiver: acceptance rate switches between full, mostly
    // ready and mostly stalled; one band of items sees no stalls at all.
    always @(negedge aclk) begin
        if (cycle_count % 64 == 0) begin
            case ($urandom_range(0, 2))
                0:       ready_pct = 100;
                1:       ready_pct = 75;
                default: ready_pct = 30;
            endcase
        end
        if (!aresetn)
            m_tready <= 1'b0;
        else if ((sent_count / 100) % 4 == 2)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    // Handshake tracking and result check, sampled at the rising edge.
    always @(posedge aclk) begin
        mac_result_t exp_r;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multiply_accumulate_long: mismatch");
            $finish;
        end else if (aresetn) begin
            last_taken = s_tvalid && s_tready;
            if (last_taken) begin
                product_queue.push_back(predict_mac(op_queue.pop_front()));
                sent_count++;
            end
            if (m_tvalid && m_tready) begin
                if (product_queue.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                end else begin
                    exp_r = product_queue.pop_front();
                    check_field("result_low",    exp_r.lo, m_tdata[31:0]);
                    check_field("result_high",   exp_r.hi, m_tdata[63:32]);
                    check_field("flag_negative", 32'(exp_r.fn), 32'(m_tdata[64]));
                    check_field("flag_zero",     32'(exp_r.fz), 32'(m_tdata[65]));
                    check_field("high_valid",    32'(exp_r.hv), 32'(m_tuser[0]));
                    check_field("flags_write",   32'(exp_r.fw), 32'(m_tuser[1]));
                end
            end
        end
    end

endmodule

// File: filelist.f
hdl/mal_pkg.sv
hdl/mal_mult.sv
hdl/mal_add.sv
hdl/mal_out.sv
hdl/multiply_accumulate_long.sv
tb/multiply_accumulate_long_tb.sv
